// ===== design/csle_pkg.sv =====
// csle_pkg: shared types, constants and helper functions for the C string
// literal extractor. No dependencies; used by every module in design/.
`default_nettype none

package csle_pkg;

    // file size limit that sets the counter saturation points
    localparam int unsigned MAX_FILE_BYTES = 2097152;

    localparam int unsigned LINE_W = 22;
    localparam int unsigned OFF_W  = 21;

    localparam int unsigned LINE_MAX_U = (1 << LINE_W) - 1;
    localparam int unsigned OFF_MAX_U  = (1 << OFF_W) - 1;

    localparam int unsigned LINE_CAP_U =
        (MAX_FILE_BYTES < LINE_MAX_U) ? MAX_FILE_BYTES : LINE_MAX_U;
    localparam int unsigned OFF_CAP_U =
        ((MAX_FILE_BYTES - 1) < OFF_MAX_U) ? (MAX_FILE_BYTES - 1) : OFF_MAX_U;

    localparam logic [LINE_W-1:0] LINE_CAP = LINE_W'(LINE_CAP_U);
    localparam logic [OFF_W-1:0]  OFF_CAP  = OFF_W'(OFF_CAP_U);

    // output queue size
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

    // character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // lexer states
    typedef enum logic [13:0] {
        ST_NORM         = 14'h0001,
        ST_NORM_SLASH   = 14'h0002,
        ST_BLK          = 14'h0004,
        ST_BLK_STAR     = 14'h0008,
        ST_LINE         = 14'h0010,
        ST_CHR          = 14'h0020,
        ST_CHR_ESC      = 14'h0040,
        ST_LIT          = 14'h0080,
        ST_LIT_ESC      = 14'h0100,
        ST_GAP          = 14'h0200,
        ST_GAP_SLASH    = 14'h0400,
        ST_GAP_BLK      = 14'h0800,
        ST_GAP_BLK_STAR = 14'h1000,
        ST_GAP_LINE     = 14'h2000
    } lex_state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] src_byte;
    } csle_in_t;

    typedef struct packed {
        logic              is_run_end;
        logic [7:0]        char_value;
        logic [LINE_W-1:0] open_line;
        logic [OFF_W-1:0]  run_offset;
        logic              last_of_item;
    } csle_out_t;

    // results of one lexer step toward the output queue
    typedef struct packed {
        logic [1:0] n;
        csle_out_t  r0;
        csle_out_t  r1;
    } csle_step_t;

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        logic [7:0] d;
        case (c)
            CH_LC_N:   d = CH_NL;
            CH_LC_T:   d = CH_TAB;
            CH_LC_R:   d = CH_CR;
            CH_LC_A:   d = CH_BEL;
            CH_LC_B:   d = CH_BS;
            CH_LC_F:   d = CH_FF;
            CH_LC_V:   d = CH_VT;
            CH_DQUOTE: d = CH_DQUOTE;
            CH_BSLASH: d = CH_BSLASH;
            CH_SQUOTE: d = CH_SQUOTE;
            default:   d = CH_QMARK;
        endcase
        return d;
    endfunction

    function automatic csle_out_t make_res(input logic is_end, input logic [7:0] ch,
                                           input logic [LINE_W-1:0] ln,
                                           input logic [OFF_W-1:0] off);
        csle_out_t r;
        r.is_run_end   = is_end;
        r.char_value   = ch;
        r.open_line    = ln;
        r.run_offset   = off;
        r.last_of_item = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/csle_lexer.sv =====
// csle_lexer: lexer state machine with line/offset counters; one byte per step.
// Depends on csle_pkg.
`default_nettype none

module csle_lexer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire csle_pkg::csle_in_t  item,
    output csle_pkg::csle_step_t     step
);
    import csle_pkg::*;

    lex_state_t        state_reg, state_next;
    logic [LINE_W-1:0] line_reg;
    logic [OFF_W-1:0]  byte_reg;
    logic [LINE_W-1:0] start_line_reg;
    logic [OFF_W-1:0]  start_off_reg;

    logic       bump;
    logic       open_lit;
    logic       code;
    logic [7:0] c;
    csle_out_t  res_char;
    csle_out_t  res_end;

    assign c        = item.src_byte;
    assign res_end  = make_res(1'b1, 8'h00, start_line_reg, start_off_reg);
    assign res_char = make_res(1'b0, c, start_line_reg, start_off_reg);

    // next state and results for the current word
    always_comb
    begin
        state_next = state_reg;
        bump       = 1'b0;
        open_lit   = 1'b0;
        code       = 1'b0;
        step.n     = 2'd0;
        step.r0    = res_end;
        step.r1    = res_end;
        if (item.mode)
        begin
            state_next = ST_NORM;
            if (state_reg == ST_LIT_ESC)
            begin
                step.r0 = make_res(1'b0, CH_BSLASH, start_line_reg, start_off_reg);
                step.n  = 2'd2;
            end
            else if (state_reg == ST_LIT || state_reg == ST_GAP
                     || state_reg == ST_GAP_SLASH || state_reg == ST_GAP_BLK
                     || state_reg == ST_GAP_BLK_STAR || state_reg == ST_GAP_LINE)
            begin
                step.n = 2'd1;
            end
        end
        else
        begin
            case (state_reg)
                ST_NORM_SLASH:
                begin
                    if (c == CH_STAR)
                        state_next = ST_BLK;
                    else if (c == CH_SLASH)
                        state_next = ST_LINE;
                    else
                        code = 1'b1;
                end
                ST_BLK, ST_BLK_STAR:
                begin
                    bump = (c == CH_NL);
                    if (state_reg == ST_BLK_STAR && c == CH_SLASH)
                        state_next = ST_NORM;
                    else
                        state_next = (c == CH_STAR) ? ST_BLK_STAR : ST_BLK;
                end
                ST_LINE:
                begin
                    if (c == CH_NL)
                    begin
                        bump       = 1'b1;
                        state_next = ST_NORM;
                    end
                end
                ST_CHR:
                begin
                    if (c == CH_SQUOTE)
                        state_next = ST_NORM;
                    else if (c == CH_BSLASH)
                        state_next = ST_CHR_ESC;
                    else
                        bump = (c == CH_NL);
                end
                ST_CHR_ESC:
                begin
                    bump       = (c == CH_NL);
                    state_next = ST_CHR;
                end
                ST_LIT:
                begin
                    if (c == CH_DQUOTE)
                        state_next = ST_GAP;
                    else if (c == CH_BSLASH)
                        state_next = ST_LIT_ESC;
                    else
                    begin
                        bump    = (c == CH_NL);
                        step.r0 = res_char;
                        step.n  = 2'd1;
                    end
                end
                ST_LIT_ESC:
                begin
                    if (c == CH_NL)
                        bump = 1'b1;
                    else
                    begin
                        step.r0 = make_res(1'b0, decode_escape(c), start_line_reg,
                                           start_off_reg);
                        step.n  = 2'd1;
                    end
                    state_next = ST_LIT;
                end
                ST_GAP:
                begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
                        state_next = ST_GAP;
                    else if (c == CH_NL)
                        bump = 1'b1;
                    else if (c == CH_DQUOTE)
                        state_next = ST_LIT;
                    else if (c == CH_SLASH)
                        state_next = ST_GAP_SLASH;
                    else
                    begin
                        step.n = 2'd1;
                        code   = 1'b1;
                    end
                end
                ST_GAP_SLASH:
                begin
                    if (c == CH_STAR)
                        state_next = ST_GAP_BLK;
                    else if (c == CH_SLASH)
                        state_next = ST_GAP_LINE;
                    else
                    begin
                        step.n = 2'd1;
                        code   = 1'b1;
                    end
                end
                ST_GAP_BLK, ST_GAP_BLK_STAR:
                begin
                    bump = (c == CH_NL);
                    if (state_reg == ST_GAP_BLK_STAR && c == CH_SLASH)
                        state_next = ST_GAP;
                    else
                        state_next = (c == CH_STAR) ? ST_GAP_BLK_STAR : ST_GAP_BLK;
                end
                ST_GAP_LINE:
                begin
                    if (c == CH_NL)
                    begin
                        bump       = 1'b1;
                        state_next = ST_GAP;
                    end
                end
                default:
                begin
                    code = 1'b1;
                end
            endcase

            // ordinary code byte
            if (code)
            begin
                if (c == CH_NL)
                begin
                    bump       = 1'b1;
                    state_next = ST_NORM;
                end
                else if (c == CH_SLASH)
                    state_next = ST_NORM_SLASH;
                else if (c == CH_SQUOTE)
                    state_next = ST_CHR;
                else if (c == CH_DQUOTE)
                begin
                    open_lit   = 1'b1;
                    state_next = ST_LIT;
                end
                else
                    state_next = ST_NORM;
            end
        end

        // mark the final result of this word
        if (step.n == 2'd2)
            step.r1.last_of_item = 1'b1;
        else
            step.r0.last_of_item = 1'b1;
    end

    // state and counters; end of file returns everything to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_NORM;
            line_reg       <= LINE_W'(1);
            byte_reg       <= '0;
            start_line_reg <= LINE_W'(1);
            start_off_reg  <= '0;
        end
        else if (go)
        begin
            if (item.mode)
            begin
                state_reg      <= ST_NORM;
                line_reg       <= LINE_W'(1);
                byte_reg       <= '0;
                start_line_reg <= LINE_W'(1);
                start_off_reg  <= '0;
            end
            else
            begin
                state_reg <= state_next;
                if (bump && line_reg < LINE_CAP)
                    line_reg <= line_reg + LINE_W'(1);
                if (byte_reg < OFF_CAP)
                    byte_reg <= byte_reg + OFF_W'(1);
                if (open_lit)
                begin
                    start_line_reg <= line_reg;
                    start_off_reg  <= byte_reg;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/csle_out_fifo.sv =====
// csle_out_fifo: small result queue taking up to two words per cycle.
// Depends on csle_pkg.
`default_nettype none

module csle_out_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire csle_pkg::csle_step_t  step,
    output logic                       room,
    output logic [csle_pkg::OQ_AW:0]   level,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output csle_pkg::csle_out_t        out_word
);
    import csle_pkg::*;

    csle_out_t          mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OQ_AW:0]     count_reg;
    logic [OQ_AW-1:0]   wr_ptr_1;
    logic [1:0]         n_push;
    logic               pop;

    assign n_push    = push ? step.n : 2'd0;
    assign pop       = out_valid && out_ready;
    assign wr_ptr_1  = wr_ptr_reg + OQ_AW'(1);
    assign room      = (count_reg <= (OQ_AW + 1)'(OQ_DEPTH - 2));
    assign level     = count_reg;
    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem_reg[wr_ptr_reg] <= step.r0;
        if (n_push == 2'd2)
            mem_reg[wr_ptr_1] <= step.r1;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + OQ_AW'(n_push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OQ_AW'(1);
            count_reg <= count_reg + (OQ_AW + 1)'(n_push) - (OQ_AW + 1)'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== design/c_string_literal_extractor_core.sv =====
// c_string_literal_extractor_core: top level; input register, lexer, result queue.
// Depends on csle_pkg, csle_lexer and csle_out_fifo.
//
//   port group                        dir  contents
//   in_valid / in_ready / in_word     in   source byte or end-of-file word
//   out_valid / out_ready / out_word  out  decoded character or run end
//
// One byte per cycle while the result queue has room: a word is held in the input
// register, then the lexer step moves it to the result queue (0, 1 or 2 result words).
// The input register advances whenever the queue has room for two results,
// so a stalled output stops input once three results wait in the 4-entry queue.
// Reset (rst_n low, asynchronous) sets normal code state, line 1, offset 0;
// an end-of-file word does the same after flushing the open run.
`default_nettype none

module c_string_literal_extractor_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire csle_pkg::csle_in_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output csle_pkg::csle_out_t      out_word
);
    import csle_pkg::*;

    logic            in_vld_reg;
    csle_in_t        in_word_reg;
    logic            step_go;
    logic            oq_room;
    logic [OQ_AW:0]  oq_level;
    csle_step_t      step;

    assign step_go  = in_vld_reg && oq_room;
    assign in_ready = !in_vld_reg || step_go;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_word_reg <= in_word;
    end

    // lexer step
    csle_lexer u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (step_go),
        .item  (in_word_reg),
        .step  (step)
    );

    // result queue
    csle_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_go),
        .step      (step),
        .room      (oq_room),
        .level     (oq_level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // queue never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_level <= (OQ_AW + 1)'(OQ_DEPTH))
        else $error("result queue overfilled");

    // only an end-of-file word gives two results
    a_two_only_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && step.n == 2'd2) |-> in_word_reg.mode)
        else $error("two results from a source byte");

    // a single result closes its word
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && step.n == 2'd1) |-> step.r0.last_of_item)
        else $error("single result missing last mark");

    // run end words carry a zero character
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.is_run_end) |-> (out_word.char_value == 8'h00))
        else $error("run end with nonzero character");

endmodule

`default_nettype wire
